FILE: design/rmfh_pkg.sv
// Package for the recursive lock with FIFO wait queue.
// Holds sizes, status codes, FSM states and the queue interface structs.
// No dependencies.
package rmfh_pkg;

    localparam int MAX_TASKS  = 32;
    localparam int COUNT_BITS = 16;
    localparam int TASK_W     = 5;
    localparam int PTR_W      = $clog2(MAX_TASKS);
    localparam int FILL_W     = PTR_W + 1;

    typedef logic [TASK_W-1:0]     task_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [PTR_W-1:0]      ptr_t;
    typedef logic [FILL_W-1:0]     fill_t;

    localparam count_t COUNT_MAX = '1;
    localparam fill_t  FILL_FULL = FILL_W'(MAX_TASKS);

    // Request codes
    localparam logic REQ_LOCK   = 1'b0;
    localparam logic REQ_UNLOCK = 1'b1;

    typedef enum logic [2:0] {
        ST_ACQUIRED    = 3'd0,
        ST_NESTED      = 3'd1,
        ST_QUEUED      = 3'd2,
        ST_NESTED_REL  = 3'd3,
        ST_FREED       = 3'd4,
        ST_HANDOFF     = 3'd5,
        ST_IGNORED     = 3'd6,
        ST_REJECTED    = 3'd7
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_POP  = 1'b1
    } fsm_t;

    // Commands from the lock logic to the wait queue
    typedef struct packed {
        logic push;
        logic pop;
    } queue_cmd_t;

    // Queue status back to the lock logic
    typedef struct packed {
        logic  empty;
        logic  full;
        fill_t fill;
    } queue_stat_t;

endpackage

FILE: design/rmfh_wait_queue.sv
// Wait queue: circular buffer of task ids in a synchronous memory.
// Pop reads the head entry; the data is registered and valid in the cycle after the pop.
// Depends on rmfh_pkg.
module rmfh_wait_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rmfh_pkg::queue_cmd_t    cmd,
    input  rmfh_pkg::task_t         push_task,
    output rmfh_pkg::queue_stat_t   stat,
    output rmfh_pkg::task_t         head_task
);
    import rmfh_pkg::*;

    task_t mem [MAX_TASKS];
    task_t rd_data_reg;
    ptr_t  head_reg, head_next;
    ptr_t  tail_reg, tail_next;
    fill_t fill_reg, fill_next;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_inc = (p == PTR_W'(MAX_TASKS - 1)) ? '0 : p + 1'b1;
    endfunction

    // Pointer and fill update
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (cmd.push)
        begin
            tail_next = ptr_inc(tail_reg);
            fill_next = fill_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            head_next = ptr_inc(head_reg);
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[tail_reg] <= push_task;
        end
        if (cmd.pop)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign stat.empty = (fill_reg == '0);
    assign stat.full  = (fill_reg >= FILL_FULL);
    assign stat.fill  = fill_reg;
    assign head_task  = rd_data_reg;

endmodule

FILE: design/recursive_mutex_fifo_handoff_top.sv
// Recursive lock with FIFO wait queue: top level with request decode and result register.
// Depends on rmfh_pkg and rmfh_wait_queue.
//
// One request item in, one result item out. An unlock that hands the lock to the oldest
// waiter passes through the POP state, since the waiter's id comes from the wait-queue
// memory, which has a registered read port. A new item is taken as soon as the lock logic
// is idle and the result register is empty or being drained, so the rate is one item per
// cycle, except that no new item is taken during a handoff. Waiters are kept in a
// MAX_TASKS-deep memory; locks that find the queue full or the count at its maximum are
// answered with status rejected and change nothing. No clearing pass is needed after reset.
module recursive_mutex_fifo_handoff_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                req_type,
    input  rmfh_pkg::task_t     task_id,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          status,
    output logic                lock_held,
    output rmfh_pkg::task_t     owner_task,
    output rmfh_pkg::count_t    hold_count,
    output logic                woken_valid,
    output rmfh_pkg::task_t     woken_task
);
    import rmfh_pkg::*;

    fsm_t        state_reg, state_next;
    task_t       owner_reg, owner_next;
    count_t      count_reg, count_next;

    logic        ov_reg, ov_next;
    status_t     st_reg, st_next;
    logic        held_reg, held_next;
    task_t       own_out_reg, own_out_next;
    count_t      cnt_out_reg, cnt_out_next;
    logic        wv_reg, wv_next;
    task_t       wt_reg, wt_next;

    queue_cmd_t  q_cmd;
    queue_stat_t q_stat;
    task_t       q_head;

    logic        accept;
    logic        out_free;
    logic        held;

    rmfh_wait_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .push_task (task_id),
        .stat      (q_stat),
        .head_task (q_head)
    );

    assign out_free = !ov_reg || !out_stall;
    assign in_stall = !((state_reg == FSM_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;
    assign held     = (count_reg != '0);

    // Request decode, lock state update and result formation
    always_comb
    begin
        state_next   = state_reg;
        owner_next   = owner_reg;
        count_next   = count_reg;
        q_cmd        = '0;
        ov_next      = ov_reg && out_stall;
        st_next      = st_reg;
        held_next    = held_reg;
        own_out_next = own_out_reg;
        cnt_out_next = cnt_out_reg;
        wv_next      = wv_reg;
        wt_next      = wt_reg;

        case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    wv_next = 1'b0;
                    wt_next = '0;
                    if (req_type == REQ_LOCK)
                    begin
                        if (!held)
                        begin
                            owner_next = task_id;
                            count_next = count_t'(1);
                            st_next    = ST_ACQUIRED;
                        end
                        else if (owner_reg == task_id)
                        begin
                            if (count_reg == COUNT_MAX)
                            begin
                                st_next = ST_REJECTED;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                st_next    = ST_NESTED;
                            end
                        end
                        else if (q_stat.full)
                        begin
                            st_next = ST_REJECTED;
                        end
                        else
                        begin
                            q_cmd.push = 1'b1;
                            st_next    = ST_QUEUED;
                        end
                    end
                    else
                    begin
                        if (!held || owner_reg != task_id)
                        begin
                            st_next = ST_IGNORED;
                        end
                        else if (count_reg > count_t'(1))
                        begin
                            count_next = count_reg - 1'b1;
                            st_next    = ST_NESTED_REL;
                        end
                        else if (!q_stat.empty)
                        begin
                            // head read is in flight; finish next cycle
                            q_cmd.pop  = 1'b1;
                            state_next = FSM_POP;
                        end
                        else
                        begin
                            owner_next = '0;
                            count_next = '0;
                            st_next    = ST_FREED;
                        end
                    end

                    if (state_next == FSM_IDLE)
                    begin
                        ov_next      = 1'b1;
                        held_next    = (count_next != '0);
                        own_out_next = (count_next != '0) ? owner_next : '0;
                        cnt_out_next = count_next;
                    end
                end
            end

            FSM_POP:
            begin
                // result register was emptied when this item was taken
                owner_next   = q_head;
                count_next   = count_t'(1);
                state_next   = FSM_IDLE;
                ov_next      = 1'b1;
                st_next      = ST_HANDOFF;
                held_next    = 1'b1;
                own_out_next = q_head;
                cnt_out_next = count_t'(1);
                wv_next      = 1'b1;
                wt_next      = q_head;
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Control and lock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            owner_reg <= '0;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            owner_reg <= owner_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        st_reg      <= st_next;
        held_reg    <= held_next;
        own_out_reg <= own_out_next;
        cnt_out_reg <= cnt_out_next;
        wv_reg      <= wv_next;
        wt_reg      <= wt_next;
    end

    assign out_valid   = ov_reg;
    assign status      = st_reg;
    assign lock_held   = held_reg;
    assign owner_task  = own_out_reg;
    assign hold_count  = cnt_out_reg;
    assign woken_valid = wv_reg;
    assign woken_task  = wt_reg;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.fill <= FILL_FULL)
        else $error("wait queue fill above depth");

    a_pop_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_POP) |=> (out_valid && woken_valid && lock_held))
        else $error("handoff did not produce a result");

    a_woken_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (woken_valid == (status == ST_HANDOFF)))
        else $error("woken flag disagrees with status");

    a_held_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lock_held == (hold_count != '0)))
        else $error("held flag disagrees with count");

endmodule
